@@ rtl/core/affinity_round_robin_picker_top_assert.svh @@
// Assertion macros for the affinity round-robin picker.
// Used by the top level; needs no other file.
`ifndef AFFINITY_ROUND_ROBIN_PICKER_TOP_ASSERT_SVH
`define AFFINITY_ROUND_ROBIN_PICKER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define ARRP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("picker assertion failed");
`define ARRP_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("picker assertion failed");
`else
`define ARRP_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define ARRP_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

@@ rtl/core/arrp_pkg.sv @@
// Package for the affinity round-robin picker: sequencer states, codes, defaults.
// No dependencies.
package arrp_pkg;

    localparam int NUM_CPUS_DEF  = 8;
    localparam int NUM_SLOTS_DEF = 64;

    localparam int TASK_W  = 16;
    localparam int AFF_W   = 4;
    localparam int WORD_W  = 64;
    localparam int CPU_F_W = 3;
    localparam int SLOT_F_W = 6;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_SCHED = 1'b1;

    localparam logic [AFF_W-1:0]  AFF_ANY    = 4'hF;
    localparam logic [TASK_W-1:0] TASK_EMPTY = 16'h0000;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_START,
        ST_SCAN,
        ST_SAVE,
        ST_FETCH,
        ST_RESULT
    } arrp_state_t;

endpackage

@@ rtl/core/affinity_round_robin_picker_top.sv @@
// Top level of the affinity round-robin picker: sequencer, scan and result register.
// Depends on arrp_pkg, arrp_ram and affinity_round_robin_picker_top_assert.svh.

// Each CPU owns a table of NUM_SLOTS task slots held in RAM. After reset the
// block clears all NUM_CPUS*NUM_SLOTS entries of the task-id RAM, one entry
// per cycle, and shows s_tready low meanwhile. A load transfer writes one slot
// in its single accept cycle, so loads stream at one per cycle. A schedule
// transfer holds s_tready low until its result is loaded. The sequencer goes
// from START to SCAN; the scan reads one slot per cycle through the single
// read port of the task table and stops at the first eligible slot. On a hit
// it then saves the stack pointer, fetches the chosen slot and loads the output
// register; with no eligible slot or an out-of-range CPU it loads the output
// register straight away. The result register lets the next transfer be
// accepted while a result still waits on m_tready.
module affinity_round_robin_picker_top
    import arrp_pkg::*;
#(
    parameter int NUM_CPUS  = NUM_CPUS_DEF,
    parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // cpu[2:0], slot[8:3], task_id[24:9], affinity[28:25],
    // stack_pointer[92:29], table_root[156:93], zero pad [159:157]
    input  logic [159:0] s_tdata,
    // action[0]
    input  logic [0:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // chosen_slot[5:0], next_stack[69:6], next_root[133:70],
    // switch_root[134], zero pad [135]
    output logic [135:0] m_tdata,
    // found[0]
    output logic [0:0]   m_tuser
);

`include "affinity_round_robin_picker_top_assert.svh"

    localparam int CPU_W  = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
    localparam int SLOT_W = $clog2(NUM_SLOTS);
    localparam int DEPTH  = NUM_CPUS * NUM_SLOTS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(NUM_SLOTS + 1);

    logic [CPU_F_W-1:0]  in_cpu;
    logic [SLOT_F_W-1:0] in_slot;
    logic [TASK_W-1:0]   in_task;
    logic [AFF_W-1:0]    in_aff;
    logic [WORD_W-1:0]   in_sp;
    logic [WORD_W-1:0]   in_root;
    logic                in_cpu_ok;
    logic                in_slot_ok;
    logic                accept;
    logic                load_ok;
    logic                sched_acc;
    logic [ADDR_W-1:0]   in_base;
    logic [ADDR_W-1:0]   ld_addr;

    arrp_state_t state_reg, state_next;

    logic [ADDR_W-1:0]   clr_cnt_reg;
    logic [CPU_F_W-1:0]  cpu_reg;
    logic [CPU_W-1:0]    cpu_idx_reg;
    logic [ADDR_W-1:0]   base_reg;
    logic [WORD_W-1:0]   sp_reg;
    logic [SLOT_W-1:0]   cur_idx_reg;
    logic                cur_vld_reg;
    logic [NUM_CPUS-1:0] cur_valid_reg;
    logic [SLOT_W-1:0]   pos_reg;
    logic [CNT_W-1:0]    issued_reg;
    logic                chk_vld_reg;
    logic [SLOT_W-1:0]   chk_pos_reg;
    logic                chk_last_reg;
    logic                found_reg;
    logic [SLOT_W-1:0]   found_slot_reg;
    logic                m_tvalid_reg;
    logic [135:0]        m_tdata_reg;
    logic [0:0]          m_tuser_reg;

    logic                clr_done;
    logic                hit;
    logic                scan_end;
    logic                result_load;
    logic [SLOT_W-1:0]   start_pos;

    logic                task_we;
    logic [ADDR_W-1:0]   task_waddr;
    logic [TASK_W-1:0]   task_wdata;
    logic                scan_re;
    logic [ADDR_W-1:0]   scan_addr;
    logic [TASK_W-1:0]   task_q;
    logic [AFF_W-1:0]    aff_q;
    logic                stack_we;
    logic [ADDR_W-1:0]   stack_waddr;
    logic [WORD_W-1:0]   stack_wdata;
    logic                fetch_re;
    logic [ADDR_W-1:0]   fetch_addr;
    logic [WORD_W-1:0]   stack_q;
    logic [WORD_W-1:0]   root_q;
    logic                cur_we;
    logic [SLOT_W-1:0]   cur_q;

    function automatic logic slot_eligible(input logic [TASK_W-1:0] t,
                                           input logic [AFF_W-1:0] a,
                                           input logic [CPU_F_W-1:0] c);
        return (t != TASK_EMPTY) && ((a == AFF_ANY) || (a == {1'b0, c}));
    endfunction

    assign in_cpu  = s_tdata[2:0];
    assign in_slot = s_tdata[8:3];
    assign in_task = s_tdata[24:9];
    assign in_aff  = s_tdata[28:25];
    assign in_sp   = s_tdata[92:29];
    assign in_root = s_tdata[156:93];

    assign in_cpu_ok  = 32'(in_cpu) < NUM_CPUS;
    assign in_slot_ok = 32'(in_slot) < NUM_SLOTS;
    assign accept     = s_tvalid && s_tready;
    assign load_ok    = accept && (s_tuser[0] == ACT_LOAD) && in_cpu_ok && in_slot_ok;
    assign sched_acc  = accept && (s_tuser[0] == ACT_SCHED);
    assign in_base    = ADDR_W'(ADDR_W'(in_cpu) * ADDR_W'(NUM_SLOTS));
    assign ld_addr    = in_base + ADDR_W'(in_slot);

    assign clr_done    = clr_cnt_reg == ADDR_W'(DEPTH - 1);
    assign hit         = chk_vld_reg && slot_eligible(task_q, aff_q, cpu_reg);
    assign scan_end    = chk_vld_reg && chk_last_reg && !hit;
    assign result_load = (state_reg == ST_RESULT) && (!m_tvalid_reg || m_tready);
    assign start_pos   = !cur_valid_reg[cpu_idx_reg] ? '0 :
                         (cur_q == SLOT_W'(NUM_SLOTS - 1)) ? '0 : cur_q + SLOT_W'(1);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_done) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (sched_acc) state_next = in_cpu_ok ? ST_START : ST_RESULT;
            end
            ST_START: state_next = ST_SCAN;
            ST_SCAN: begin
                if (hit) begin
                    state_next = ST_SAVE;
                end else if (scan_end) begin
                    state_next = ST_RESULT;
                end
            end
            ST_SAVE:  state_next = ST_FETCH;
            ST_FETCH: state_next = ST_RESULT;
            ST_RESULT: begin
                if (result_load) state_next = ST_IDLE;
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_comb begin
        s_tready    = 1'b0;
        task_we     = load_ok;
        task_waddr  = ld_addr;
        task_wdata  = in_task;
        scan_re     = 1'b0;
        stack_we    = load_ok;
        stack_waddr = ld_addr;
        stack_wdata = in_sp;
        fetch_re    = 1'b0;
        cur_we      = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                task_we    = 1'b1;
                task_waddr = clr_cnt_reg;
                task_wdata = TASK_EMPTY;
            end
            ST_IDLE:  s_tready = 1'b1;
            ST_SCAN:  scan_re = (32'(issued_reg) < NUM_SLOTS) && !hit;
            ST_SAVE: begin
                stack_we    = cur_vld_reg;
                stack_waddr = base_reg + ADDR_W'(cur_idx_reg);
                stack_wdata = sp_reg;
                cur_we      = 1'b1;
            end
            ST_FETCH: fetch_re = 1'b1;
            default: ;
        endcase
    end

    assign scan_addr  = base_reg + ADDR_W'(pos_reg);
    assign fetch_addr = base_reg + ADDR_W'(found_slot_reg);

    arrp_ram #(.WIDTH(TASK_W), .DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_task_ram (
        .aclk(aclk), .we(task_we), .waddr(task_waddr), .wdata(task_wdata),
        .re(scan_re), .raddr(scan_addr), .rdata(task_q)
    );

    arrp_ram #(.WIDTH(AFF_W), .DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_aff_ram (
        .aclk(aclk), .we(load_ok), .waddr(ld_addr), .wdata(in_aff),
        .re(scan_re), .raddr(scan_addr), .rdata(aff_q)
    );

    arrp_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_stack_ram (
        .aclk(aclk), .we(stack_we), .waddr(stack_waddr), .wdata(stack_wdata),
        .re(fetch_re), .raddr(fetch_addr), .rdata(stack_q)
    );

    arrp_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_root_ram (
        .aclk(aclk), .we(load_ok), .waddr(ld_addr), .wdata(in_root),
        .re(fetch_re), .raddr(fetch_addr), .rdata(root_q)
    );

    arrp_ram #(.WIDTH(SLOT_W), .DEPTH(NUM_CPUS), .ADDR_W(CPU_W)) u_cur_ram (
        .aclk(aclk), .we(cur_we), .waddr(cpu_idx_reg), .wdata(found_slot_reg),
        .re(sched_acc), .raddr(CPU_W'(in_cpu)), .rdata(cur_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            cur_valid_reg <= '0;
            chk_vld_reg   <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
            if (state_reg == ST_SAVE) cur_valid_reg[cpu_idx_reg] <= 1'b1;
            chk_vld_reg <= scan_re;
            if (result_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (sched_acc) begin
            cpu_reg     <= in_cpu;
            cpu_idx_reg <= CPU_W'(in_cpu);
            base_reg    <= in_base;
            sp_reg      <= in_sp;
            found_reg   <= 1'b0;
        end
        if (state_reg == ST_START) begin
            cur_vld_reg <= cur_valid_reg[cpu_idx_reg];
            cur_idx_reg <= cur_q;
            pos_reg     <= start_pos;
            issued_reg  <= '0;
        end
        if (scan_re) begin
            pos_reg      <= (pos_reg == SLOT_W'(NUM_SLOTS - 1)) ? '0 : pos_reg + SLOT_W'(1);
            issued_reg   <= issued_reg + CNT_W'(1);
            chk_pos_reg  <= pos_reg;
            chk_last_reg <= 32'(issued_reg) == NUM_SLOTS - 1;
        end
        if ((state_reg == ST_SCAN) && hit) begin
            found_reg      <= 1'b1;
            found_slot_reg <= chk_pos_reg;
        end
        if (result_load) begin
            m_tuser_reg[0]     <= found_reg;
            m_tdata_reg[5:0]   <= found_reg ? 6'(found_slot_reg) : 6'd0;
            m_tdata_reg[69:6]  <= found_reg ? stack_q : sp_reg;
            m_tdata_reg[133:70] <= found_reg ? root_q : '0;
            m_tdata_reg[134]   <= found_reg && (root_q != '0);
            m_tdata_reg[135]   <= 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `ARRP_ASSERT_IMP(a_scan_bound, aclk, aresetn, state_reg == ST_SCAN, 32'(issued_reg) <= NUM_SLOTS)
    `ARRP_ASSERT_NXT(a_save_sets_current, aclk, aresetn, state_reg == ST_SAVE, cur_valid_reg[cpu_idx_reg])
    `ARRP_ASSERT_NXT(a_result_waits, aclk, aresetn, (state_reg == ST_RESULT) && m_tvalid && !m_tready, (state_reg == ST_RESULT) && m_tvalid)
    `ARRP_ASSERT_NXT(a_load_stays_idle, aclk, aresetn, accept && (s_tuser[0] == ACT_LOAD), state_reg == ST_IDLE)

endmodule

@@ rtl/core/arrp_ram.sv @@
// Single-port-write, single-port-read RAM with registered read data.
// Uses arrp_pkg for its parameter defaults.
module arrp_ram
    import arrp_pkg::*;
#(
    parameter int WIDTH  = WORD_W,
    parameter int DEPTH  = NUM_SLOTS_DEF,
    parameter int ADDR_W = $clog2(NUM_SLOTS_DEF)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
